>>> rtl/thh_pkg.sv
// Package for the thermistor hysteresis heater block.
// Holds shared widths, constants, register codes and state types.
// No dependencies.
`default_nettype none

package thh_pkg;

  // Default parameter values.
  localparam int unsigned ADC_BITS_DEF      = 12;
  localparam int unsigned LOG_FRAC_BITS_DEF = 16;

  // Fixed field and port widths.
  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned ADC_W_MAX  = 16;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned TEMP_W     = 19;

  // Logarithm unit widths: operand, mantissa fraction bits, exponent.
  localparam int unsigned X_W       = 40;
  localparam int unsigned MANT_BITS = 30;
  localparam int unsigned K_W       = 6;

  // Quotient bits of the final division; larger quotients saturate.
  localparam int unsigned QUO_W = 18;

  localparam logic [31:0]     LN2_Q32       = 32'd2977044472;
  localparam logic [15:0]     RAW_ZERO_N    = 16'd32999;
  localparam logic [6:0]      CENTI         = 7'd100;
  localparam logic [19:0]     KELVIN_OFFSET = 20'd27315;
  localparam logic [19:0]     TEMP_MAX      = 20'd200000;

  // Reset values of the configuration registers.
  localparam logic [15:0] BETA_RST  = 16'd3950;
  localparam logic [23:0] R_NOM_RST = 24'd100000;
  localparam logic [23:0] R_SER_RST = 24'd100000;
  localparam logic [15:0] T_NOM_RST = 16'd29815;
  localparam logic [18:0] LOWER_RST = 19'd19500;
  localparam logic [18:0] UPPER_RST = 19'd20500;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BETA  = 3'd0,
    REG_R_NOM = 3'd1,
    REG_R_SER = 3'd2,
    REG_T_NOM = 3'd3,
    REG_LOWER = 3'd4,
    REG_UPPER = 3'd5
  } thh_reg_e;

  // Sequencer of the top level.
  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_START,
    S_WAIT,
    S_LN,
    S_DEN,
    S_SUM,
    S_CHK,
    S_DIV,
    S_FIN
  } thh_state_e;

  // Sequencer of the logarithm unit.
  typedef enum logic [1:0] {
    L_IDLE,
    L_NORM,
    L_SQ
  } thh_log_state_e;

endpackage

`default_nettype wire

>>> rtl/thh_log2.sv
// Iterative base-2 logarithm of a positive 40-bit integer.
// Normalizes with a small shift step, then squares the mantissa once per fraction bit.
// Depends on thh_pkg.
`default_nettype none

module thh_log2 #(
  parameter int unsigned LOG_FRAC_BITS = thh_pkg::LOG_FRAC_BITS_DEF
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   start_i,
  input  wire logic [thh_pkg::X_W-1:0]                x_i,
  output logic                                        done_o,
  output logic [thh_pkg::K_W+LOG_FRAC_BITS-1:0]       log2_o
);

  localparam int unsigned CNT_W = $clog2(LOG_FRAC_BITS);
  localparam int unsigned M_W   = thh_pkg::MANT_BITS + 1;
  localparam int unsigned SQ_W  = 2 * M_W;

  thh_pkg::thh_log_state_e state_q, state_d;

  logic [thh_pkg::X_W-1:0]   x_q;
  logic [thh_pkg::K_W-1:0]   k_q;
  logic [M_W-1:0]            m_q;
  logic [LOG_FRAC_BITS-1:0]  frac_q;
  logic [CNT_W-1:0]          cnt_q;
  logic                      done_q;

  logic [SQ_W-1:0]           sq;
  logic [M_W:0]              sq_top;
  logic                      top_byte_zero;
  logic                      last_bit;

  // Mantissa square, truncated back to the mantissa fraction bits.
  assign sq            = m_q * m_q;
  assign sq_top        = sq[SQ_W-1:thh_pkg::MANT_BITS];
  assign top_byte_zero = (x_q[thh_pkg::X_W-1 -: 8] == 8'd0);
  assign last_bit      = (cnt_q == CNT_W'(LOG_FRAC_BITS - 1));

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= thh_pkg::L_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == thh_pkg::L_SQ) && last_bit;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      thh_pkg::L_IDLE: begin
        if (start_i) state_d = thh_pkg::L_NORM;
      end
      thh_pkg::L_NORM: begin
        if (!top_byte_zero && x_q[thh_pkg::X_W-1]) state_d = thh_pkg::L_SQ;
      end
      thh_pkg::L_SQ: begin
        if (last_bit) state_d = thh_pkg::L_IDLE;
      end
      default: state_d = thh_pkg::L_IDLE;
    endcase
  end

  // Datapath: normalize, then one squaring step per cycle.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      thh_pkg::L_IDLE: begin
        if (start_i) begin
          x_q <= x_i;
          k_q <= thh_pkg::K_W'(thh_pkg::X_W - 1);
        end
      end
      thh_pkg::L_NORM: begin
        if (top_byte_zero) begin
          x_q <= {x_q[thh_pkg::X_W-9:0], 8'd0};
          k_q <= k_q - thh_pkg::K_W'(8);
        end else if (!x_q[thh_pkg::X_W-1]) begin
          x_q <= {x_q[thh_pkg::X_W-2:0], 1'b0};
          k_q <= k_q - thh_pkg::K_W'(1);
        end else begin
          m_q   <= x_q[thh_pkg::X_W-1 -: M_W];
          cnt_q <= '0;
        end
      end
      thh_pkg::L_SQ: begin
        if (sq_top[M_W]) begin
          m_q <= sq_top[M_W:1];
        end else begin
          m_q <= sq_top[M_W-1:0];
        end
        frac_q <= {frac_q[LOG_FRAC_BITS-2:0], sq_top[M_W]};
        cnt_q  <= cnt_q + CNT_W'(1);
      end
      default: begin
        cnt_q <= '0;
      end
    endcase
  end

  assign done_o = done_q;
  assign log2_o = {k_q, frac_q};

endmodule

`default_nettype wire

>>> rtl/thermistor_hysteresis_heater.sv
// Top level: NTC thermistor temperature from one ADC item, Beta equation, heater hysteresis.
// Uses thh_log2 for both logarithms and a restoring divider for the final quotient.
// Depends on thh_pkg and thh_log2.
//
//   channel   signals                                   direction
//   input     in_valid_i / in_ready_o, adc_sample_i     item in
//   output    out_valid_o / out_ready_i, result fields  item out
//   config    cfg_we_i, cfg_idx_i, cfg_wdata_i          register write
//
// From acceptance to a valid result: two logarithm passes, each with normalize steps and
// one squaring step per fraction bit, the denominator steps, the 18-step restoring
// divider and the output step; the block then returns to idle for the next item.
// Items with an invalid setting or zero resistance skip the arithmetic and go straight from
// acceptance to the output step; a saturating quotient skips the divider.
// Reset clears the heater to off and loads the configuration defaults.
// A finished result waits in the output register; the next item is accepted meanwhile,
// and only the final load stalls if the previous result has not been taken.
`default_nettype none

module thermistor_hysteresis_heater #(
  parameter int unsigned ADC_BITS      = thh_pkg::ADC_BITS_DEF,
  parameter int unsigned LOG_FRAC_BITS = thh_pkg::LOG_FRAC_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [thh_pkg::SAMPLE_W-1:0]     adc_sample_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic signed [thh_pkg::TEMP_W-1:0]     temperature_centi_o,
  output logic                                  heater_drive_o,
  output logic                                  range_fault_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [thh_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [thh_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);

  localparam int unsigned F      = LOG_FRAC_BITS;
  localparam int unsigned LG_W   = thh_pkg::K_W + F;
  localparam int unsigned LN_W   = LG_W;
  localparam int unsigned LNP_W  = LG_W + 33;
  localparam int unsigned LQ_W   = LN_W + 1;
  localparam int unsigned PR_W   = LQ_W + 17;
  localparam int unsigned DEN_W  = F + 25;
  localparam int unsigned UD_W   = DEN_W - 1;
  localparam int unsigned RW     = F + 43;
  localparam int unsigned QCNT_W = $clog2(thh_pkg::QUO_W);
  localparam int unsigned T_W    = thh_pkg::TEMP_W;

  // Configuration registers.
  logic [15:0]     beta_q, t0_q;
  logic [23:0]     rnom_q, rser_q;
  logic [T_W-1:0]  lower_q, upper_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beta_q  <= thh_pkg::BETA_RST;
      rnom_q  <= thh_pkg::R_NOM_RST;
      rser_q  <= thh_pkg::R_SER_RST;
      t0_q    <= thh_pkg::T_NOM_RST;
      lower_q <= thh_pkg::LOWER_RST;
      upper_q <= thh_pkg::UPPER_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        thh_pkg::REG_BETA:  beta_q  <= cfg_wdata_i[15:0];
        thh_pkg::REG_R_NOM: rnom_q  <= cfg_wdata_i;
        thh_pkg::REG_R_SER: rser_q  <= cfg_wdata_i;
        thh_pkg::REG_T_NOM: t0_q    <= cfg_wdata_i[15:0];
        thh_pkg::REG_LOWER: lower_q <= cfg_wdata_i[T_W-1:0];
        thh_pkg::REG_UPPER: upper_q <= cfg_wdata_i[T_W-1:0];
        default: ;
      endcase
    end
  end

  // Divider ratio terms of the incoming item.
  logic [thh_pkg::ADC_W_MAX-1:0] samp_ext;
  logic [ADC_BITS-1:0]           raw;
  logic [15:0]                   n_in, d_in;
  logic                          item_ok;

  assign samp_ext = thh_pkg::ADC_W_MAX'(adc_sample_i);
  assign raw      = samp_ext[ADC_BITS-1:0];
  assign n_in     = (raw == '0) ? thh_pkg::RAW_ZERO_N : 16'({ADC_BITS{1'b1}} - raw);
  assign d_in     = (raw == '0) ? 16'd1 : 16'(raw);
  assign item_ok  = (beta_q != '0) && (rnom_q != '0) && (t0_q != '0) &&
                    (n_in != '0) && (rser_q != '0);

  // Sequencer and datapath registers.
  thh_pkg::thh_state_e state_q, state_d;

  logic                  op_b_q, fault_q;
  logic                  out_valid_q, heater_q;
  logic [15:0]           n_q, d_q;
  logic [22:0]           b100_q;
  logic [thh_pkg::X_W-1:0] x_q;
  logic [LG_W-1:0]       lg_q;
  logic [LN_W-1:0]       ln0_q, ln1_q;
  logic signed [DEN_W-1:0] prod_q, den_q;
  logic [RW-1:0]         num_q, rem_q, dv_q;
  logic [thh_pkg::QUO_W-1:0] q_q;
  logic [QCNT_W-1:0]     qcnt_q;
  logic signed [T_W-1:0] temp_q;
  logic                  fault_out_q;

  // Logarithm unit.
  logic            log_start, log_done;
  logic [LG_W-1:0] log_res;

  thh_log2 #(
    .LOG_FRAC_BITS(LOG_FRAC_BITS)
  ) u_log2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (log_start),
    .x_i     (x_q),
    .done_o  (log_done),
    .log2_o  (log_res)
  );

  // Arithmetic of the individual steps.
  logic [39:0]             x_prod;
  logic [LNP_W-1:0]        ln_prod;
  logic signed [LQ_W-1:0]  lq;
  logic signed [PR_W-1:0]  t0_lq;
  logic [38:0]             bt_prod;
  logic                    den_pos;
  logic [UD_W-1:0]         ud;
  logic [RW-1:0]           rem_init, rem_lim;
  logic                    rem_ge;
  logic signed [19:0]      temp20;
  logic                    too_hot;
  logic signed [T_W-1:0]   temp_fin;
  logic                    fault_fin;
  logic                    heater_next;
  logic                    out_free;

  assign x_prod   = op_b_q ? (40'(d_q) * 40'(rnom_q)) : (40'(rser_q) * 40'(n_q));
  assign ln_prod  = LNP_W'(lg_q) * LNP_W'(thh_pkg::LN2_Q32) + (LNP_W'(1) << 31);
  assign lq       = $signed({1'b0, ln0_q}) - $signed({1'b0, ln1_q});
  assign t0_lq    = $signed({1'b0, t0_q}) * lq;
  assign bt_prod  = 39'(b100_q) * 39'(t0_q);
  assign den_pos  = !den_q[DEN_W-1] && (den_q != '0);
  assign ud       = den_q[UD_W-1:0];
  assign rem_init = num_q + RW'(ud >> 1);
  assign rem_lim  = RW'({ud, {thh_pkg::QUO_W{1'b0}}});
  assign rem_ge   = (rem_q >= dv_q);

  // Final result: Celsius offset, saturation and hysteresis.
  assign temp20    = $signed({2'b00, q_q}) - $signed(thh_pkg::KELVIN_OFFSET);
  assign too_hot   = (temp20 > $signed(thh_pkg::TEMP_MAX));
  assign fault_fin = fault_q || too_hot;
  assign temp_fin  = fault_fin ? T_W'(thh_pkg::TEMP_MAX) : temp20[T_W-1:0];
  assign out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    heater_next = heater_q;
    if (heater_q) begin
      if (temp_fin >= $signed(upper_q)) heater_next = 1'b0;
    end else begin
      if (temp_fin <= $signed(lower_q)) heater_next = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= thh_pkg::S_IDLE;
      op_b_q      <= 1'b0;
      fault_q     <= 1'b0;
      out_valid_q <= 1'b0;
      heater_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      // The output register is loaded when free, and emptied when taken.
      if ((state_q == thh_pkg::S_FIN) && out_free) out_valid_q <= 1'b1;
      else if (out_ready_i)                        out_valid_q <= 1'b0;
      unique case (state_q)
        thh_pkg::S_IDLE: begin
          if (in_valid_i) begin
            op_b_q  <= 1'b0;
            fault_q <= !item_ok;
          end
        end
        thh_pkg::S_LN: begin
          op_b_q <= 1'b1;
        end
        thh_pkg::S_CHK: begin
          if (!den_pos || (rem_init >= rem_lim)) fault_q <= 1'b1;
        end
        thh_pkg::S_FIN: begin
          if (out_free) begin
            heater_q <= heater_next;
          end
        end
        default: ;
      endcase
    end
  end

  // Next state and control outputs.
  always_comb begin
    state_d   = state_q;
    log_start = 1'b0;
    unique case (state_q)
      thh_pkg::S_IDLE: begin
        if (in_valid_i) state_d = item_ok ? thh_pkg::S_MUL : thh_pkg::S_FIN;
      end
      thh_pkg::S_MUL:   state_d = thh_pkg::S_START;
      thh_pkg::S_START: begin
        log_start = 1'b1;
        state_d   = thh_pkg::S_WAIT;
      end
      thh_pkg::S_WAIT: begin
        if (log_done) state_d = thh_pkg::S_LN;
      end
      thh_pkg::S_LN:  state_d = op_b_q ? thh_pkg::S_DEN : thh_pkg::S_MUL;
      thh_pkg::S_DEN: state_d = thh_pkg::S_SUM;
      thh_pkg::S_SUM: state_d = thh_pkg::S_CHK;
      thh_pkg::S_CHK: begin
        if (!den_pos || (rem_init >= rem_lim)) state_d = thh_pkg::S_FIN;
        else                                     state_d = thh_pkg::S_DIV;
      end
      thh_pkg::S_DIV: begin
        if (qcnt_q == QCNT_W'(thh_pkg::QUO_W - 1)) state_d = thh_pkg::S_FIN;
      end
      thh_pkg::S_FIN: begin
        if (out_free) state_d = thh_pkg::S_IDLE;
      end
      default: state_d = thh_pkg::S_IDLE;
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      thh_pkg::S_IDLE: begin
        if (in_valid_i) begin
          n_q    <= n_in;
          d_q    <= d_in;
          b100_q <= 23'(beta_q) * 23'(thh_pkg::CENTI);
        end
      end
      thh_pkg::S_MUL: x_q <= x_prod;
      thh_pkg::S_WAIT: begin
        if (log_done) lg_q <= log_res;
      end
      thh_pkg::S_LN: begin
        if (op_b_q) ln1_q <= ln_prod[LN_W+31:32];
        else        ln0_q <= ln_prod[LN_W+31:32];
      end
      thh_pkg::S_DEN: prod_q <= DEN_W'(t0_lq);
      thh_pkg::S_SUM: begin
        den_q <= $signed(DEN_W'({b100_q, {F{1'b0}}})) + prod_q;
        num_q <= RW'({bt_prod, {F{1'b0}}});
      end
      thh_pkg::S_CHK: begin
        rem_q  <= rem_init;
        dv_q   <= RW'({ud, {(thh_pkg::QUO_W-1){1'b0}}});
        qcnt_q <= '0;
      end
      thh_pkg::S_DIV: begin
        if (rem_ge) rem_q <= rem_q - dv_q;
        q_q    <= {q_q[thh_pkg::QUO_W-2:0], rem_ge};
        dv_q   <= dv_q >> 1;
        qcnt_q <= qcnt_q + QCNT_W'(1);
      end
      thh_pkg::S_FIN: begin
        if (out_free) begin
          temp_q      <= temp_fin;
          fault_out_q <= fault_fin;
        end
      end
      default: ;
    endcase
  end

  assign in_ready_o          = (state_q == thh_pkg::S_IDLE);
  assign out_valid_o         = out_valid_q;
  assign temperature_centi_o = temp_q;
  assign heater_drive_o      = heater_q;
  assign range_fault_o       = fault_out_q;

endmodule

`default_nettype wire

>>> rtl/thh_checker.sv
// Port-level checker for the thermistor hysteresis heater, bound to the top level.
// Watches only the top level's ports.
// Depends on thh_pkg.
`default_nettype none

module thh_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             in_valid_i,
  input wire logic                             in_ready_o,
  input wire logic [thh_pkg::SAMPLE_W-1:0]     adc_sample_i,
  input wire logic                             out_valid_o,
  input wire logic                             out_ready_i,
  input wire logic signed [thh_pkg::TEMP_W-1:0] temperature_centi_o,
  input wire logic                             heater_drive_o,
  input wire logic                             range_fault_o
);

  // A waiting result holds until taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(temperature_centi_o) &&
    $stable(range_fault_o) && $stable(heater_drive_o))
    else $error("result changed while stalled");

  // A faulted result always carries the saturated temperature.
  a_fault_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && range_fault_o |-> temperature_centi_o == 19'sd200000)
    else $error("fault without saturated temperature");

  // A reported temperature stays within the physical range.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> temperature_centi_o >= -19'sd27315 &&
    temperature_centi_o <= 19'sd200000)
    else $error("temperature out of range");

  // After taking an item the block is busy computing it.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready right after an accepted item");

  // An offered item stays put until it is taken.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(adc_sample_i))
    else $error("input item changed while waiting");

endmodule

bind thermistor_hysteresis_heater thh_checker u_thh_checker (.*);

`default_nettype wire

>>> tb/sv/tb_top.sv
// Self-checking testbench for thermistor_hysteresis_heater.
// It predicts the temperature, heater and fault of every item and checks each result.
// Depends on thh_pkg and the thermistor_hysteresis_heater RTL.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 4000000;
  localparam int unsigned N_PHASES    = 8;
  localparam int unsigned PHASE_ITEMS = 235;
  localparam longint     T_MAX        = 200000;
  localparam longint     K_OFS        = 27315;
  localparam longint     RATIO_CLAMP  = 33000;
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned MBITS       = 30;
  localparam longint unsigned LN2_FIX = 64'd2977044472;

  // One result of the block.
  typedef struct {
    logic signed [thh_pkg::TEMP_W-1:0] temp;
    logic                              heater;
    logic                              fault;
  } reading_t;

  // One row of the directed table; typed rows carry their expected reading.
  typedef struct {
    logic [thh_pkg::SAMPLE_W-1:0] sample;
    bit                           typed;
    reading_t                     want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  logic [thh_pkg::SAMPLE_W-1:0] adc_sample_i;
  logic out_valid_o;
  logic out_ready_i;
  logic signed [thh_pkg::TEMP_W-1:0] temperature_centi_o;
  logic heater_drive_o;
  logic range_fault_o;
  logic cfg_we_i;
  logic [thh_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [thh_pkg::CFG_DATA_W-1:0] cfg_wdata_i;

  // Predictor copy of the configuration and of the heater.
  logic [15:0] beta_q;
  logic [23:0] r_nom_q;
  logic [23:0] r_ser_q;
  logic [15:0] t_nom_q;
  logic signed [thh_pkg::TEMP_W-1:0] lower_q;
  logic signed [thh_pkg::TEMP_W-1:0] upper_q;
  logic heater_q;

  reading_t pending_readings[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit no_idle = 1'b0;

  thermistor_hysteresis_heater u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .adc_sample_i       (adc_sample_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .temperature_centi_o(temperature_centi_o),
    .heater_drive_o     (heater_drive_o),
    .range_fault_o      (range_fault_o),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // Run limit.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // log2 of x with FRAC_BITS fraction bits, by repeated squaring of the mantissa.
  function automatic longint unsigned log2_fix(longint unsigned x);
    longint unsigned t, m, frac;
    int unsigned k;
    t = x;
    k = 0;
    frac = 0;
    while (t > 1) begin
      t = t >> 1;
      k++;
    end
    if (k >= MBITS) m = x >> (k - MBITS);
    else m = x << (MBITS - k);
    for (int i = 0; i < FRAC_BITS; i++) begin
      m = (m * m) >> MBITS;
      frac = frac << 1;
      if (m >= (64'd2 << MBITS)) begin
        m = m >> 1;
        frac = frac | 1;
      end
    end
    return (longint'(k) << FRAC_BITS) | frac;
  endfunction

  function automatic longint ln_fix(longint unsigned x);
    return longint'((log2_fix(x) * LN2_FIX + (64'd1 << 31)) >> 32);
  endfunction

  // Temperature, fault and new heater state for one sample; updates the heater.
  function automatic reading_t convert_sample(logic [thh_pkg::SAMPLE_W-1:0] raw);
    reading_t r;
    longint unsigned n, d, b100, num, ud;
    longint temp, lq, den;
    bit fault;
    temp = T_MAX;
    fault = 1'b1;
    if (raw == 0) begin
      n = RATIO_CLAMP - 1;
      d = 1;
    end else begin
      n = 4095 - raw;
      d = raw;
    end
    if (beta_q != 0 && r_nom_q != 0 && t_nom_q != 0 && n != 0 && r_ser_q != 0) begin
      lq = ln_fix(longint'(r_ser_q) * n) - ln_fix(d * longint'(r_nom_q));
      b100 = 100 * longint'(beta_q);
      den = longint'(b100 << FRAC_BITS) + longint'(t_nom_q) * lq;
      if (den > 0) begin
        num = (b100 * longint'(t_nom_q)) << FRAC_BITS;
        ud = den;
        temp = longint'((num + ud / 2) / ud) - K_OFS;
        if (temp > T_MAX) temp = T_MAX;
        else fault = 1'b0;
      end
    end
    // Hysteresis: off at or above the upper level, on at or below the lower one.
    if (heater_q) begin
      if (temp >= longint'(upper_q)) heater_q = 1'b0;
    end else begin
      if (temp <= longint'(lower_q)) heater_q = 1'b1;
    end
    r.temp = temp[thh_pkg::TEMP_W-1:0];
    r.heater = heater_q;
    r.fault = fault;
    return r;
  endfunction

  // Register write; the block is idle whenever this is called.
  task automatic write_reg(thh_pkg::thh_reg_e idx, logic [thh_pkg::CFG_DATA_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      thh_pkg::REG_BETA:  beta_q = val[15:0];
      thh_pkg::REG_R_NOM: r_nom_q = val;
      thh_pkg::REG_R_SER: r_ser_q = val;
      thh_pkg::REG_T_NOM: t_nom_q = val[15:0];
      thh_pkg::REG_LOWER: lower_q = val[thh_pkg::TEMP_W-1:0];
      thh_pkg::REG_UPPER: upper_q = val[thh_pkg::TEMP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_all(logic [15:0] beta, logic [23:0] rn, logic [23:0] rs,
                           logic [15:0] tn, int lo, int hi);
    write_reg(thh_pkg::REG_BETA, 24'(beta));
    write_reg(thh_pkg::REG_R_NOM, rn);
    write_reg(thh_pkg::REG_R_SER, rs);
    write_reg(thh_pkg::REG_T_NOM, 24'(tn));
    write_reg(thh_pkg::REG_LOWER, 24'(lo));
    write_reg(thh_pkg::REG_UPPER, 24'(hi));
  endtask

  // Offer one item; called at a rising edge, returns at the edge that accepts it.
  task automatic send_sample(logic [thh_pkg::SAMPLE_W-1:0] s, bit typed, reading_t want);
    bit rdy;
    reading_t got;
    if (!no_idle && $urandom_range(99) < 34) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    adc_sample_i <= s;
    do begin
      @(negedge clk_i);
      rdy = in_ready_o;
      @(posedge clk_i);
    end while (!rdy);
    got = convert_sample(s);
    pending_readings.push_back(typed ? want : got);
  endtask

  // Wait until every reading has come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Receiver stalls.
  always @(posedge clk_i) begin
    out_ready_i <= no_idle ? 1'b1 : ($urandom_range(99) >= 34);
  end

  // Result checker: sampled at the falling edge, accepted at the next rising one.
  always @(negedge clk_i) begin
    reading_t w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_readings.size() == 0) begin
        $display("%0t: unexpected item temp=%0d heater=%0b fault=%0b", $time,
                 temperature_centi_o, heater_drive_o, range_fault_o);
        mismatches++;
      end else begin
        w = pending_readings.pop_front();
        if (temperature_centi_o !== w.temp) begin
          $display("%0t: temperature expected %0d actual %0d", $time, w.temp,
                   temperature_centi_o);
          mismatches++;
        end
        if (heater_drive_o !== w.heater) begin
          $display("%0t: heater expected %0b actual %0b", $time, w.heater, heater_drive_o);
          mismatches++;
        end
        if (range_fault_o !== w.fault) begin
          $display("%0t: fault expected %0b actual %0b", $time, w.fault, range_fault_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    stim_row_t rows[$];
    reading_t sat;
    reading_t none;
    logic [thh_pkg::SAMPLE_W-1:0] s;
    int waited;
    sat.temp = 19'sd200000;
    sat.heater = 1'b0;
    sat.fault = 1'b1;
    none = sat;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    adc_sample_i <= '0;
    out_ready_i <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= thh_pkg::REG_BETA;
    cfg_wdata_i <= '0;
    beta_q = thh_pkg::BETA_RST;
    r_nom_q = thh_pkg::R_NOM_RST;
    r_ser_q = thh_pkg::R_SER_RST;
    t_nom_q = thh_pkg::T_NOM_RST;
    lower_q = thh_pkg::LOWER_RST;
    upper_q = thh_pkg::UPPER_RST;
    heater_q = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table: the clamped zero reading is very cold and turns the heater on,
    // zero resistance is saturated and turns it off again; the rest spans cold,
    // room and hot readings so that the heater toggles.
    rows.push_back('{12'd0, 1'b0, none});
    rows.push_back('{12'd4095, 1'b1, sat});
    rows.push_back('{12'd1, 1'b0, none});
    rows.push_back('{12'd4094, 1'b0, none});
    rows.push_back('{12'd2048, 1'b0, none});
    rows.push_back('{12'd3900, 1'b0, none});
    rows.push_back('{12'd200, 1'b0, none});
    rows.push_back('{12'd3900, 1'b0, none});
    rows.push_back('{12'd100, 1'b0, none});
    rows.push_back('{12'hAAA, 1'b0, none});
    rows.push_back('{12'h555, 1'b0, none});
    rows.push_back('{12'd2047, 1'b0, none});
    rows.push_back('{12'd0, 1'b0, none});
    rows.push_back('{12'd50, 1'b0, none});
    rows.push_back('{12'd4095, 1'b0, none});
    foreach (rows[i]) send_sample(rows[i].sample, rows[i].typed, rows[i].want);
    drain();

    // Phases with different settings, then random readings in each.
    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: write_all(16'd1, 24'd1, 24'd1, 16'd1, -27315, 200000);
        1: write_all(16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 200000, -27315);
        2: write_all(16'd0, 24'd100000, 24'd0, 16'd29815, 19500, 20500);
        3: write_all(16'd3950, 24'd0, 24'd10000, 16'd0, 0, 5000);
        4: write_all(16'd1, 24'hFFFFFF, 24'd1, 16'hFFFF, -27315, -27315);
        default: write_all(16'($urandom_range(4500, 3000)),
                           24'($urandom_range(200000, 1000)),
                           24'($urandom_range(200000, 1000)),
                           16'($urandom_range(31000, 27000)),
                           int'($urandom_range(20000, 0)),
                           int'($urandom_range(40000, 15000)));
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        no_idle = (p == 6 && i >= 40 && i < 200);
        if ($urandom_range(9) < 2) begin
          case ($urandom_range(3))
            0: s = 12'd0;
            1: s = 12'd1;
            2: s = 12'd4094;
            default: s = 12'd4095;
          endcase
        end else begin
          s = 12'($urandom_range(4095));
        end
        send_sample(s, 1'b0, none);
      end
      no_idle = 1'b0;
      drain();
    end

    waited = 0;
    while (pending_readings.size() != 0 && waited < 1000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (100) @(posedge clk_i);
    if (mismatches == 0 && pending_readings.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
